FILE: rtl/core/lcdbi_pkg.sv
package lcdbi_pkg;

  localparam int unsigned PanelWidth  = 240;
  localparam int unsigned PanelHeight = 320;
  localparam int unsigned PixCount    = PanelWidth * PanelHeight;
  localparam int unsigned PixAw       = $clog2(PixCount);

  localparam logic [1:0] CmdIndexWr = 2'd0;
  localparam logic [1:0] CmdCtrlRd  = 2'd1;
  localparam logic [1:0] CmdDataWr  = 2'd2;
  localparam logic [1:0] CmdDataRd  = 2'd3;

  localparam logic [7:0] IdxId      = 8'h00;
  localparam logic [7:0] IdxDrvOut  = 8'h01;
  localparam logic [7:0] IdxEntry   = 8'h03;
  localparam logic [7:0] IdxCol     = 8'h20;
  localparam logic [7:0] IdxRow     = 8'h21;
  localparam logic [7:0] IdxPixPort = 8'h22;
  localparam logic [7:0] IdxHsta    = 8'h50;
  localparam logic [7:0] IdxHend    = 8'h51;
  localparam logic [7:0] IdxVsta    = 8'h52;
  localparam logic [7:0] IdxVend    = 8'h53;

  localparam logic [15:0] IdReset = 16'h9335;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] bus_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       read_valid;
  } out_item_t;

  function automatic logic [15:0] mask_of(input logic [7:0] idx);
    logic [15:0] m;
    unique case (idx)
      8'h01: m = 16'h0500;
      8'h03: m = 16'hD0B8;
      8'h05: m = 16'h0003;
      8'h07: m = 16'h313B;
      8'h08: m = 16'hFFFF;
      8'h09: m = 16'h073F;
      8'h0A: m = 16'h000F;
      8'h0C: m = 16'h7133;
      8'h0D: m = 16'h01FF;
      8'h0F: m = 16'h001B;
      8'h10: m = 16'h17F3;
      8'h11: m = 16'h0777;
      8'h12: m = 16'h008F;
      8'h13: m = 16'h1F00;
      8'h20: m = 16'h00FF;
      8'h21: m = 16'h01FF;
      8'h29: m = 16'h003F;
      8'h2B: m = 16'h000F;
      8'h30, 8'h31, 8'h32, 8'h35, 8'h37, 8'h38, 8'h39, 8'h3C: m = 16'h0707;
      8'h36, 8'h3D: m = 16'h1F0F;
      8'h50, 8'h51: m = 16'h00FF;
      8'h52, 8'h53: m = 16'h01FF;
      8'h60: m = 16'hBF3F;
      8'h61: m = 16'h0007;
      8'h6A, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85: m = 16'h01FF;
      8'h90: m = 16'h031F;
      8'h92: m = 16'h0700;
      8'h95: m = 16'h0300;
      8'h97: m = 16'h0F00;
      8'hA1: m = 16'h083F;
      8'hA2: m = 16'hFF01;
      8'hA5: m = 16'hFFFF;
      8'hE6: m = 16'h0001;
      default: m = 16'h0000;
    endcase
    return m;
  endfunction

  function automatic logic [17:0] swap_rb(input logic [17:0] p);
    return {p[5:0], p[11:6], p[17:12]};
  endfunction

endpackage

FILE: rtl/core/lcd_controller_bus_interface_core.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_ready_o   | lcdbi_pkg::in_item_t (cmd, bus_byte)
// out     | output    | out_valid_o / out_ready_i | lcdbi_pkg::out_item_t (read_byte, read_valid)
//
// One transfer is in flight: the accept cycle drives the memory read addresses, the
// execute cycle sees the read data and writes back, and the result register presents the
// result in the Out state. Input is taken again after it leaves.
// After reset a clearing pass zeroes the 76800-entry pixel memory and the register memory,
// one entry per cycle; no transfer is taken until the pass ends.
// A stalled output holds the result and blocks the input until the result is taken.
module lcd_controller_bus_interface_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lcdbi_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lcdbi_pkg::out_item_t out_data_o
);
  import lcdbi_pkg::*;

  typedef enum logic [3:0] {
    StClear = 4'b0001,
    StIdle  = 4'b0010,
    StExec  = 4'b0100,
    StOut   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // pixel memory
  logic [17:0]      pix_mem [PixCount];
  logic [17:0]      pix_rdata_q;
  logic             pix_we;
  logic [PixAw-1:0] pix_waddr, pix_raddr;
  logic [17:0]      pix_wdata;
  logic [PixAw-1:0] clr_cnt_q;

  // register memory; the registers that steer the pixel path also live in flops below
  logic [15:0] reg_mem [256];
  logic [15:0] reg_rdata_q;
  logic        reg_we;
  logic [7:0]  reg_waddr;
  logic [15:0] reg_wdata;

  logic [15:0] drvout_q, entry_q, col_q, row_q;
  logic [15:0] hsta_q, hend_q, vsta_q, vend_q;

  logic [15:0] reg_index_q;
  logic [23:0] asm_q;
  logic [1:0]  wphase_q;
  logic        rphase_q;
  logic [7:0]  shcol_q;
  logic [8:0]  shrow_q;
  in_item_t    item_q;
  logic        pix_inpanel_q;
  out_item_t   out_q, out_d;

  wire [15:0] em   = entry_q;
  wire [15:0] col  = col_q;
  wire [15:0] row  = row_q;
  wire        in_panel = (col < 16'(PanelWidth)) && (row < 16'(PanelHeight));
  wire [PixAw-1:0] rd_addr = PixAw'(row[8:0]) * PixAw'(PanelWidth) + PixAw'(col[7:0]);
  wire [7:0]  col_m  = drvout_q[8] ? 8'(PanelWidth - 1) - col[7:0] : col[7:0];
  wire [PixAw-1:0] wr_addr = PixAw'(row[8:0]) * PixAw'(PanelWidth) + PixAw'(col_m);

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      pix_mem[pix_waddr] <= pix_wdata;
    end
    pix_rdata_q <= pix_mem[pix_raddr];
  end
  assign pix_raddr = rd_addr;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_cnt_q == PixAw'(PixCount - 1)) state_d = StIdle;
      StIdle:  if (in_valid_i) state_d = StExec;
      StExec:  state_d = StOut;
      StOut:   if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // pixel byte assembly for the current write
  logic [23:0] asm_n;
  logic [1:0]  wph_n;
  logic        pix_commit;
  logic [17:0] pix_raw, pix_fin;
  logic [15:0] w16;
  always_comb begin
    asm_n = {asm_q[15:0], item_q.bus_byte};
    wph_n = wphase_q + 2'd1;
    w16   = asm_n[15:0];
    pix_commit = 1'b0;
    pix_raw = '0;
    if (em[15]) begin
      if (wph_n == 2'd3) begin
        pix_commit = 1'b1;
        pix_raw = em[14] ? asm_n[17:0] : {asm_n[23:18], asm_n[15:10], asm_n[7:2]};
      end
    end else if (wph_n >= 2'd2) begin
      pix_commit = 1'b1;
      pix_raw = {w16[15:11], w16[15], w16[10:5], w16[4:0], w16[4]};
    end
    pix_fin = em[12] ? swap_rb(pix_raw) : pix_raw;
  end

  wire exec_pixwr = (state_q == StExec) && (item_q.cmd == CmdDataWr) &&
                    (reg_index_q == 16'(IdxPixPort));

  always_comb begin
    if (state_q == StClear) begin
      pix_we = 1'b1;
      pix_waddr = clr_cnt_q;
      pix_wdata = '0;
    end else begin
      pix_we = exec_pixwr && pix_commit && in_panel;
      pix_waddr = wr_addr;
      pix_wdata = pix_fin;
    end
  end

  // cursor step helper
  function automatic logic [16:0] step(input logic [15:0] cur, input logic [15:0] lo,
                                       input logic [15:0] hi, input logic up);
    logic [15:0] n;
    logic        w;
    if (up) begin
      w = cur >= hi;
      n = (cur < hi) ? cur + 16'd1 : lo;
    end else begin
      w = cur <= lo;
      n = (cur > lo) ? cur - 16'd1 : hi;
    end
    return {w, n};
  endfunction

  logic [16:0] sc, sr;
  logic [15:0] ncol, nrow;
  always_comb begin
    sc = step(col, hsta_q, hend_q, em[4]);
    sr = step(row, vsta_q, vend_q, em[5]);
    ncol = col;
    nrow = row;
    if (em[3]) begin
      nrow = sr[15:0];
      if (sr[16]) ncol = sc[15:0];
    end else begin
      ncol = sc[15:0];
      if (sc[16]) nrow = sr[15:0];
    end
  end

  // register read value for data read
  logic [17:0] prd;
  logic [15:0] rdv;
  always_comb begin
    prd = pix_inpanel_q ? pix_rdata_q : 18'd0;
    if (em[12]) prd = swap_rb(prd);
    if (reg_index_q == 16'(IdxPixPort)) begin
      rdv = {prd[17:13], prd[11:6], prd[5:1]};
    end else if (reg_index_q[15:8] != 8'd0) begin
      rdv = 16'd0;
    end else begin
      unique case (reg_index_q[7:0])
        IdxId:     rdv = IdReset;
        IdxDrvOut: rdv = drvout_q;
        IdxEntry:  rdv = entry_q;
        IdxCol:    rdv = col_q;
        IdxRow:    rdv = row_q;
        IdxHsta:   rdv = hsta_q;
        IdxHend:   rdv = hend_q;
        IdxVsta:   rdv = vsta_q;
        IdxVend:   rdv = vend_q;
        default:   rdv = reg_rdata_q;
      endcase
    end
  end

  // result of the access in execution
  always_comb begin
    out_d = '0;
    unique case (item_q.cmd)
      CmdCtrlRd: out_d.read_valid = 1'b1;
      CmdDataRd: begin
        out_d.read_valid = 1'b1;
        out_d.read_byte  = rphase_q ? rdv[7:0] : rdv[15:8];
      end
      default: ;
    endcase
  end

  // register write value under the mask of the selected register
  logic [15:0] wval;
  assign wval = asm_n[15:0] & mask_of(reg_index_q[7:0]);

  logic do_regwr;
  assign do_regwr = (state_q == StExec) && (item_q.cmd == CmdDataWr) &&
                    (reg_index_q != 16'(IdxPixPort)) && (wphase_q != 2'd0) &&
                    (reg_index_q[15:8] == 8'd0) && (reg_index_q[7:0] != IdxId);

  // cursor and target updates; drop the target write for cursor regs in reload mode
  logic [15:0] ucol, urow, utgt;
  logic        wcol, wrow, wtgt;
  always_comb begin
    ucol = col; urow = row; utgt = wval;
    wcol = 1'b0; wrow = 1'b0; wtgt = 1'b1;
    unique case (reg_index_q[7:0])
      IdxEntry: if (wval[7]) begin
        wcol = 1'b1; wrow = 1'b1;
        ucol = wval[4] ? hsta_q : hend_q;
        urow = wval[5] ? vsta_q : vend_q;
      end
      IdxCol: if (em[7]) begin
        wcol = 1'b1; wtgt = 1'b0;
        ucol = em[4] ? hsta_q : hend_q;
      end else begin
        wrow = 1'b1; urow = {7'd0, shrow_q};
      end
      IdxRow: if (em[7]) begin
        wrow = 1'b1; wtgt = 1'b0;
        urow = em[5] ? vsta_q : vend_q;
      end else begin
        wcol = 1'b1; ucol = {8'd0, shcol_q};
      end
      IdxHsta: if ((em & 16'h00A0) != 16'd0) begin wcol = 1'b1; ucol = wval; end
      IdxHend: if ((em & 16'h00A0) == 16'h0080) begin wcol = 1'b1; ucol = wval; end
      IdxVsta: if ((em & 16'h0090) != 16'd0) begin wrow = 1'b1; urow = wval; end
      IdxVend: if ((em & 16'h0090) == 16'h0080) begin wrow = 1'b1; urow = wval; end
      default: ;
    endcase
    // a write that targets the cursor itself lands through the cursor update
    if (wtgt && reg_index_q[7:0] == IdxCol) begin wcol = 1'b1; ucol = utgt; end
    if (wtgt && reg_index_q[7:0] == IdxRow) begin wrow = 1'b1; urow = utgt; end
  end

  // register memory port: clear during the pixel clearing pass, else write back
  always_comb begin
    if (state_q == StClear) begin
      reg_we    = 1'b1;
      reg_waddr = clr_cnt_q[7:0];
      reg_wdata = '0;
    end else begin
      reg_we    = do_regwr && wtgt;
      reg_waddr = reg_index_q[7:0];
      reg_wdata = utgt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (reg_we) begin
      reg_mem[reg_waddr] <= reg_wdata;
    end
    reg_rdata_q <= reg_mem[reg_index_q[7:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= '0;
      reg_index_q <= '0;
      asm_q       <= '0;
      wphase_q    <= '0;
      rphase_q    <= 1'b0;
      shcol_q     <= '0;
      shrow_q     <= '0;
      item_q      <= '0;
      pix_inpanel_q <= 1'b0;
      out_q       <= '0;
      drvout_q    <= '0;
      entry_q     <= '0;
      col_q       <= '0;
      row_q       <= '0;
      hsta_q      <= '0;
      hend_q      <= '0;
      vsta_q      <= '0;
      vend_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_cnt_q <= clr_cnt_q + PixAw'(1);
      if (state_q == StIdle && in_valid_i) begin
        item_q        <= in_data_i;
        pix_inpanel_q <= in_panel;
      end
      if (state_q == StExec) begin
        out_q <= out_d;
        unique case (item_q.cmd)
          CmdIndexWr: begin
            reg_index_q <= {reg_index_q[7:0], item_q.bus_byte};
            rphase_q <= 1'b0;
            wphase_q <= '0;
          end
          CmdCtrlRd: ;
          CmdDataRd: rphase_q <= ~rphase_q;
          CmdDataWr: begin
            asm_q <= asm_n;
            if (reg_index_q == 16'(IdxPixPort)) begin
              wphase_q <= pix_commit ? 2'd0 : wph_n;
              if (pix_commit) begin
                col_q <= ncol;
                row_q <= nrow;
              end
            end else begin
              wphase_q <= (wphase_q != 2'd0) ? 2'd0 : 2'd1;
              if (do_regwr) begin
                if (wcol) col_q <= ucol;
                if (wrow) row_q <= urow;
                if (wtgt) begin
                  unique case (reg_index_q[7:0])
                    IdxDrvOut: drvout_q <= utgt;
                    IdxEntry:  entry_q  <= utgt;
                    IdxHsta:   hsta_q   <= utgt;
                    IdxHend:   hend_q   <= utgt;
                    IdxVsta:   vsta_q   <= utgt;
                    IdxVend:   vend_q   <= utgt;
                    default: ;
                  endcase
                end
                if (reg_index_q[7:0] == IdxCol && !em[7]) shcol_q <= wval[7:0];
                if (reg_index_q[7:0] == IdxRow && !em[7]) shrow_q <= wval[8:0];
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("input taken while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StExec)) else $error("no exec after accept");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec) |=> out_valid_o) else $error("result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> !in_ready_o) else $error("accept during clear");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lcdbi_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  always #5 clk = ~clk;

  lcd_controller_bus_interface_core u_dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o(out_data)
  );

  // Shadow of the controller state, kept by the access predictor.
  logic [15:0] cur_index;
  logic [15:0] regs [256];
  logic [17:0] gram [PixCount];
  logic [23:0] byte_shift;
  logic [1:0] wr_count;
  logic rd_low;
  logic [7:0] keep_col;
  logic [8:0] keep_row;

  out_item_t pending_reads [$];
  int unsigned mismatches = 0;
  int unsigned transfers_sent = 0;
  int unsigned transfers_checked = 0;
  int unsigned pixels_stored = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_hold = 0;

  function automatic logic [15:0] reg_mask(input logic [7:0] idx);
    case (idx)
      8'h01: return 16'h0500;
      8'h03: return 16'hD0B8;
      8'h05: return 16'h0003;
      8'h07: return 16'h313B;
      8'h08, 8'hA5: return 16'hFFFF;
      8'h09: return 16'h073F;
      8'h0A, 8'h2B: return 16'h000F;
      8'h0C: return 16'h7133;
      8'h0F: return 16'h001B;
      8'h10: return 16'h17F3;
      8'h11: return 16'h0777;
      8'h12: return 16'h008F;
      8'h13: return 16'h1F00;
      8'h20, 8'h50, 8'h51: return 16'h00FF;
      8'h0D, 8'h21, 8'h52, 8'h53, 8'h6A,
      8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85: return 16'h01FF;
      8'h29: return 16'h003F;
      8'h30, 8'h31, 8'h32, 8'h35, 8'h37, 8'h38, 8'h39, 8'h3C: return 16'h0707;
      8'h36, 8'h3D: return 16'h1F0F;
      8'h60: return 16'hBF3F;
      8'h61: return 16'h0007;
      8'h90: return 16'h031F;
      8'h92: return 16'h0700;
      8'h95: return 16'h0300;
      8'h97: return 16'h0F00;
      8'hA1: return 16'h083F;
      8'hA2: return 16'hFF01;
      8'hE6: return 16'h0001;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [17:0] rb_swapped(input logic [17:0] p);
    return {p[5:0], p[11:6], p[17:12]};
  endfunction

  task automatic clear_shadow();
    cur_index = '0;
    foreach (regs[i]) regs[i] = '0;
    regs[IdxId] = IdReset;
    foreach (gram[i]) gram[i] = '0;
    byte_shift = '0;
    wr_count = '0;
    rd_low = 1'b0;
    keep_col = '0;
    keep_row = '0;
  endtask

  task automatic reload_cursor(input logic [15:0] mode, input bit col, input bit row);
    if (col) regs[IdxCol] = mode[4] ? regs[IdxHsta] : regs[IdxHend];
    if (row) regs[IdxRow] = mode[5] ? regs[IdxVsta] : regs[IdxVend];
  endtask

  task automatic commit_register(input logic [15:0] val);
    logic [15:0] em;
    logic [15:0] m;
    logic [15:0] mv;
    logic [7:0] idx;
    em = regs[IdxEntry];
    if (cur_index >= 256 || cur_index == 0) return;
    idx = cur_index[7:0];
    m = reg_mask(idx);
    mv = val & m;
    case (idx)
      IdxEntry: if (val[7]) reload_cursor(val, 1'b1, 1'b1);
      IdxCol: begin
        if (em[7]) begin
          reload_cursor(em, 1'b1, 1'b0);
          return;
        end
        regs[IdxRow] = {7'd0, keep_row};
        keep_col = mv[7:0];
      end
      IdxRow: begin
        if (em[7]) begin
          reload_cursor(em, 1'b0, 1'b1);
          return;
        end
        regs[IdxCol] = {8'd0, keep_col};
        keep_row = mv[8:0];
      end
      IdxHsta: if ((em & 16'h00A0) != 0) regs[IdxCol] = mv;
      IdxHend: if ((em & 16'h00A0) == 16'h0080) regs[IdxCol] = mv;
      IdxVsta: if ((em & 16'h0090) != 0) regs[IdxRow] = mv;
      IdxVend: if ((em & 16'h0090) == 16'h0080) regs[IdxRow] = mv;
      default: ;
    endcase
    regs[idx] = mv;
  endtask

  // Advance one cursor axis inside the window; return 1 on wrap.
  function automatic bit advance_axis(inout logic [15:0] pos, input logic [15:0] lo,
                                      input logic [15:0] hi, input bit up);
    bit wrap;
    if (up) begin
      wrap = pos >= hi;
      pos = (pos < hi) ? pos + 16'd1 : lo;
    end else begin
      wrap = pos <= lo;
      pos = (pos > lo) ? pos - 16'd1 : hi;
    end
    return wrap;
  endfunction

  task automatic store_pixel(input logic [17:0] p);
    logic [15:0] em;
    logic [15:0] pos;
    int unsigned x;
    int unsigned y;
    em = regs[IdxEntry];
    x = {16'd0, regs[IdxCol]};
    y = {16'd0, regs[IdxRow]};
    if (em[12]) p = rb_swapped(p);
    if (x < PanelWidth && y < PanelHeight) begin
      if (regs[IdxDrvOut][8]) x = PanelWidth - 1 - x;
      gram[y * PanelWidth + x] = p;
      pixels_stored++;
    end
    if (em[3]) begin
      pos = regs[IdxRow];
      if (advance_axis(pos, regs[IdxVsta], regs[IdxVend], em[5])) begin
        regs[IdxRow] = pos;
        pos = regs[IdxCol];
        void'(advance_axis(pos, regs[IdxHsta], regs[IdxHend], em[4]));
        regs[IdxCol] = pos;
      end else regs[IdxRow] = pos;
    end else begin
      pos = regs[IdxCol];
      if (advance_axis(pos, regs[IdxHsta], regs[IdxHend], em[4])) begin
        regs[IdxCol] = pos;
        pos = regs[IdxRow];
        void'(advance_axis(pos, regs[IdxVsta], regs[IdxVend], em[5]));
        regs[IdxRow] = pos;
      end else regs[IdxCol] = pos;
    end
  endtask

  task automatic take_data_byte(input logic [7:0] b);
    logic [15:0] em;
    logic [15:0] w;
    em = regs[IdxEntry];
    byte_shift = {byte_shift[15:0], b};
    if (cur_index == {8'd0, IdxPixPort}) begin
      wr_count = wr_count + 2'd1;
      if (em[15] && wr_count >= 3) begin
        wr_count = '0;
        if (em[14]) store_pixel(byte_shift[17:0]);
        else store_pixel({byte_shift[23:18], byte_shift[15:10], byte_shift[7:2]});
      end else if (!em[15] && wr_count >= 2) begin
        w = byte_shift[15:0];
        wr_count = '0;
        // 565 to 666: replicate the top bit of red and blue
        store_pixel({w[15:11], w[15], w[10:5], w[4:0], w[4]});
      end
    end else begin
      if (wr_count != 0) commit_register(byte_shift[15:0]);
      wr_count = (wr_count != 0) ? 2'd0 : 2'd1;
    end
  endtask

  function automatic logic [7:0] fetch_read_byte();
    logic [15:0] v;
    logic [17:0] p;
    int unsigned x;
    int unsigned y;
    if (cur_index == {8'd0, IdxPixPort}) begin
      x = {16'd0, regs[IdxCol]};
      y = {16'd0, regs[IdxRow]};
      p = '0;
      if (x < PanelWidth && y < PanelHeight) p = gram[y * PanelWidth + x];
      if (regs[IdxEntry][12]) p = rb_swapped(p);
      v = {p[17:13], p[11:6], p[5:1]};
    end else begin
      v = (cur_index < 256) ? regs[cur_index[7:0]] : 16'd0;
    end
    rd_low = ~rd_low;
    return rd_low ? v[15:8] : v[7:0];
  endfunction

  // Work out the response of one accepted access and queue it.
  task automatic predict_access(input in_item_t it);
    out_item_t res;
    res = '0;
    case (it.cmd)
      CmdIndexWr: begin
        cur_index = {cur_index[7:0], it.bus_byte};
        rd_low = 1'b0;
        wr_count = '0;
      end
      CmdCtrlRd: res.read_valid = 1'b1;
      CmdDataWr: take_data_byte(it.bus_byte);
      default: begin
        res.read_byte = fetch_read_byte();
        res.read_valid = 1'b1;
      end
    endcase
    pending_reads.push_back(res);
  endtask

  // Offer one access; keep valid high across back-to-back transfers.
  task automatic send_access(input logic [1:0] cmd, input logic [7:0] b);
    in_item_t it;
    it.cmd = cmd;
    it.bus_byte = b;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_access(it);
    transfers_sent++;
  endtask

  task automatic set_index(input logic [7:0] idx);
    send_access(CmdIndexWr, 8'h00);
    send_access(CmdIndexWr, idx);
  endtask

  task automatic write_register(input logic [7:0] idx, input logic [15:0] v);
    set_index(idx);
    send_access(CmdDataWr, v[15:8]);
    send_access(CmdDataWr, v[7:0]);
  endtask

  task automatic read_pair();
    send_access(CmdDataRd, 8'($urandom_range(255)));
    send_access(CmdDataRd, 8'($urandom_range(255)));
  endtask

  // Drop valid and wait until every queued response has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Receiver: stall at random, or hold off for a counted stretch.
  always @(posedge clk) begin
    if (recv_hold != 0) begin
      recv_hold <= recv_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every response against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        $display("unexpected response at %0t", $realtime);
        mismatches++;
      end else begin
        want = pending_reads.pop_front();
        if (out_data.read_byte !== want.read_byte)
          report_mismatch("read_byte", out_data.read_byte, want.read_byte);
        if (out_data.read_valid !== want.read_valid)
          report_mismatch("read_valid", {7'd0, out_data.read_valid},
                          {7'd0, want.read_valid});
        transfers_checked++;
      end
    end
  end

  // ID readout, control read, read-only ID, plain and unmapped registers,
  // and an index above the register file.
  task automatic test_register_access();
    set_index(IdxId);
    read_pair();
    send_access(CmdCtrlRd, 8'hFF);
    write_register(IdxId, 16'h0000);
    read_pair();
    write_register(8'h08, 16'hFFFF);
    read_pair();
    write_register(8'hFF, 16'hFFFF);
    read_pair();
    send_access(CmdIndexWr, 8'h01);
    send_access(CmdIndexWr, 8'h00);
    send_access(CmdDataWr, 8'hAA);
    send_access(CmdDataWr, 8'h55);
    read_pair();
    drain();
  endtask

  task automatic test_pixel_path();
    write_register(IdxEntry, 16'h1030);
    set_index(IdxPixPort);
    send_access(CmdDataWr, 8'hF8);
    send_access(CmdDataWr, 8'h1F);
    write_register(IdxCol, 16'h0000);
    write_register(IdxRow, 16'h0000);
    set_index(IdxPixPort);
    read_pair();
    drain();
  endtask

  // Hold the receiver off while accesses keep coming, then drain.
  task automatic test_backpressure();
    recv_hold = 300;
    set_index(IdxId);
    repeat (6) read_pair();
    drain();
  endtask

  task automatic random_window();
    logic [15:0] hs, vs;
    hs = 16'($urandom_range(0, 239));
    vs = 16'($urandom_range(0, 319));
    if ($urandom_range(9) == 0) begin
      write_register(IdxHsta, 16'($urandom));
      write_register(IdxHend, 16'($urandom));
      write_register(IdxVsta, 16'($urandom));
      write_register(IdxVend, 16'($urandom));
    end else begin
      write_register(IdxHsta, hs);
      write_register(IdxHend, 16'(hs + $urandom_range(0, 239 - hs)));
      write_register(IdxVsta, vs);
      write_register(IdxVend, 16'(vs + $urandom_range(0, 319 - vs)));
    end
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned stop;
    logic [7:0] pick [12] = '{8'h01, 8'h03, 8'h07, 8'h08, 8'h20, 8'h21,
                              8'h50, 8'h53, 8'h60, 8'hA2, 8'hE6, 8'h00};
    stop = transfers_sent + count;
    while (transfers_sent < stop) begin
      case ($urandom_range(6))
        0: write_register(IdxEntry, 16'($urandom));
        1: random_window();
        2: write_register($urandom_range(1) ? IdxCol : IdxRow, 16'($urandom));
        3: begin
          set_index(IdxPixPort);
          repeat ($urandom_range(1, 12)) send_access(CmdDataWr, 8'($urandom_range(255)));
        end
        4: begin
          set_index(IdxPixPort);
          repeat ($urandom_range(1, 3)) read_pair();
        end
        5: begin
          write_register($urandom_range(3) == 0 ? 8'($urandom_range(255))
                                                : pick[$urandom_range(11)],
                         16'($urandom));
          read_pair();
        end
        default: repeat ($urandom_range(1, 4))
          send_access(2'($urandom_range(3)), 8'($urandom_range(255)));
      endcase
    end
    drain();
  endtask

  initial begin
    clear_shadow();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_pixel_path();
    test_backpressure();
    send_idle_pct = 31;
    recv_idle_pct = 72;
    test_random_traffic(560);
    send_idle_pct = 72;
    recv_idle_pct = 31;
    test_random_traffic(560);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(560);
    repeat (20) @(posedge clk);
    $display("covered: %0d accesses, %0d responses checked, %0d pixels stored in panel",
             transfers_sent, transfers_checked, pixels_stored);
    $display("register paths, cursor stepping, 565/666 pixels and three idle mixes");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout: %0d responses still pending", pending_reads.size());
    $display("FAILURE");
    $finish;
  end

endmodule
